/* src/irsc_pkg.sv */
`timescale 1ns / 1ps
// irsc_pkg: shared types and codes for the inode slot cache
// no dependencies; used by the interfaces, controller, datapath and top level

package irsc_pkg;

   // beat field widths
   localparam int FUNC_W  = 2;
   localparam int DEV_W   = 4;
   localparam int OBJ_W   = 32;
   localparam int SLOTF_W = 6;
   localparam int STAT_W  = 2;
   localparam int REFSF_W = 16;

   // operation codes
   localparam logic [FUNC_W-1:0] FUNC_ACQUIRE = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_DUP     = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_RELEASE = 2'd2;

   // result status codes
   localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
   localparam logic [STAT_W-1:0] ST_FULL = 2'd1;
   localparam logic [STAT_W-1:0] ST_FREE = 2'd2;
   localparam logic [STAT_W-1:0] ST_OVF  = 2'd3;

   // controller to datapath
   typedef struct packed {
      logic load_req;
      logic lookup;
      logic commit;
   } irsc_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic out_busy;
   } irsc_stat_type;

endpackage

/* src/irsc_if.sv */
`timescale 1ns / 1ps
// irsc_req_if / irsc_rsp_if: valid/ready channels of the inode slot cache
// depends on irsc_pkg for field widths

interface irsc_req_if import irsc_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [FUNC_W-1:0] func;
   logic [DEV_W-1:0]  dev_num;
   logic [OBJ_W-1:0]  obj_num;
   logic [SLOTF_W-1:0] slot_in;

   modport source (output valid, func, dev_num, obj_num, slot_in, input ready);
   modport sink   (input valid, func, dev_num, obj_num, slot_in, output ready);
endinterface

interface irsc_rsp_if import irsc_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [SLOTF_W-1:0] slot_out;
   logic               was_hit;
   logic [STAT_W-1:0]  status;
   logic [REFSF_W-1:0] refs_now;

   modport source (output valid, slot_out, was_hit, status, refs_now, input ready);
   modport sink   (input valid, slot_out, was_hit, status, refs_now, output ready);
endinterface

/* src/irsc_ram.sv */
`timescale 1ns / 1ps
// irsc_ram: generic single write port, single read port ram with registered read
// no dependencies

module irsc_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* src/irsc_ctrl.sv */
`timescale 1ns / 1ps
// irsc_ctrl: sequencing state machine of the inode slot cache
// depends on irsc_pkg for the command and status structs

module irsc_ctrl import irsc_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  irsc_stat_type stat,
   output irsc_cmd_type  cmd
);

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_LOOK   = 2'd1;
   localparam logic [1:0] S_COMMIT = 2'd2;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      req_ready    = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready    = 1'b1;
            cmd.load_req = req_valid;
            if (req_valid) begin
               state_in = S_LOOK;
            end
         end
         S_LOOK: begin
            cmd.lookup = 1'b1;
            state_in   = S_COMMIT;
         end
         S_COMMIT: begin
            // hold until the result register is free
            cmd.commit = !stat.out_busy;
            if (!stat.out_busy) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

/* src/irsc_dp.sv */
`timescale 1ns / 1ps
// irsc_dp: tag store, in-use flags, count ram and result register
// depends on irsc_pkg and irsc_ram

module irsc_dp import irsc_pkg::*; #(
   parameter int SLOTS    = 64,
   parameter int REF_BITS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  irsc_cmd_type       cmd,
   output irsc_stat_type      stat,
   input  logic [FUNC_W-1:0]  req_func,
   input  logic [DEV_W-1:0]   req_dev_num,
   input  logic [OBJ_W-1:0]   req_obj_num,
   input  logic [SLOTF_W-1:0] req_slot_in,
   input  logic               rsp_ready,
   output logic               rsp_valid,
   output logic [SLOTF_W-1:0] rsp_slot_out,
   output logic               rsp_was_hit,
   output logic [STAT_W-1:0]  rsp_status,
   output logic [REFSF_W-1:0] rsp_refs_now
);

   localparam int SLOT_W = $clog2(SLOTS);
   localparam logic [REF_BITS-1:0] REF_MAX = {REF_BITS{1'b1}};

   // request beat
   logic [FUNC_W-1:0]  func_ff;
   logic [DEV_W-1:0]   dev_ff;
   logic [OBJ_W-1:0]   obj_ff;
   logic [SLOTF_W-1:0] slot_in_ff;

   // slot table
   logic [SLOTS-1:0]  in_use_ff;
   logic [SLOTS-1:0]  in_use_in;
   logic [DEV_W-1:0]  tag_dev_ff [SLOTS];
   logic [OBJ_W-1:0]  tag_obj_ff [SLOTS];

   // lookup results
   logic [SLOT_W-1:0] tgt_ff;
   logic              hit_ff;
   logic              have_free_ff;
   logic              range_ok_ff;
   logic              tgt_used_ff;

   // result register
   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   logic [SLOTF_W-1:0] rsp_slot_ff;
   logic               rsp_hit_ff;
   logic [STAT_W-1:0]  rsp_status_ff;
   logic [REFSF_W-1:0] rsp_refs_ff;

   // lookup stage
   logic                hit_found;
   logic [SLOT_W-1:0]   hit_idx;
   logic                free_found;
   logic [SLOT_W-1:0]   free_idx;
   logic [SLOT_W+SLOTF_W-1:0] slot_ext;
   logic [SLOT_W-1:0]   slot_idx;
   logic                range_ok;
   logic [SLOT_W-1:0]   look_tgt;

   // commit stage
   logic [REF_BITS-1:0] ram_rd;
   logic [REF_BITS-1:0] cnt;
   logic                at_max;
   logic [REF_BITS-1:0] res_refs;
   logic [STAT_W-1:0]   res_status;
   logic                res_hit;
   logic [SLOTF_W-1:0]  res_slot;
   logic                wr_en;
   logic [REF_BITS-1:0] wr_data;
   logic                set_use;
   logic                clr_use;
   logic                write_tag;
   logic [SLOT_W+SLOTF_W-1:0]   tgt_ext;
   logic [REF_BITS+REFSF_W-1:0] refs_ext;

   // priority encoders over the tag compare and the free flags
   always_comb begin
      hit_found  = 1'b0;
      hit_idx    = '0;
      free_found = 1'b0;
      free_idx   = '0;
      for (int i = 0; i < SLOTS; i++) begin
         if (!hit_found && in_use_ff[i] && tag_dev_ff[i] == dev_ff
             && tag_obj_ff[i] == obj_ff) begin
            hit_found = 1'b1;
            hit_idx   = SLOT_W'(i);
         end
         if (!free_found && !in_use_ff[i]) begin
            free_found = 1'b1;
            free_idx   = SLOT_W'(i);
         end
      end
   end

   assign slot_ext = {{SLOT_W{1'b0}}, slot_in_ff};
   assign slot_idx = slot_ext[SLOT_W-1:0];
   assign range_ok = 32'(slot_in_ff) < SLOTS;

   always_comb begin
      case (func_ff)
         FUNC_ACQUIRE: look_tgt = hit_found ? hit_idx : free_idx;
         default:      look_tgt = slot_idx;
      endcase
   end

   irsc_ram #(
      .WIDTH (REF_BITS),
      .DEPTH (SLOTS)
   ) u_refs_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (tgt_ff),
      .wr_data (wr_data),
      .rd_en   (cmd.lookup),
      .rd_addr (look_tgt),
      .rd_data (ram_rd)
   );

   // read-modify-write of the selected count
   assign cnt     = tgt_used_ff ? ram_rd : '0;
   assign at_max  = cnt == REF_MAX;
   assign tgt_ext = {{SLOTF_W{1'b0}}, tgt_ff};

   always_comb begin
      res_refs   = '0;
      res_status = ST_OK;
      res_hit    = 1'b0;
      res_slot   = tgt_ext[SLOTF_W-1:0];
      wr_en      = 1'b0;
      wr_data    = '0;
      set_use    = 1'b0;
      clr_use    = 1'b0;
      write_tag  = 1'b0;
      case (func_ff)
         FUNC_ACQUIRE: begin
            if (hit_ff) begin
               res_hit = 1'b1;
               if (at_max) begin
                  res_status = ST_OVF;
                  res_refs   = cnt;
               end else begin
                  res_refs = cnt + REF_BITS'(1);
                  wr_en    = 1'b1;
                  wr_data  = res_refs;
               end
            end else if (have_free_ff) begin
               res_refs  = REF_BITS'(1);
               wr_en     = 1'b1;
               wr_data   = REF_BITS'(1);
               set_use   = 1'b1;
               write_tag = 1'b1;
            end else begin
               res_status = ST_FULL;
               res_slot   = '0;
            end
         end
         FUNC_DUP, FUNC_RELEASE: begin
            if (!range_ok_ff || !tgt_used_ff) begin
               res_status = ST_FREE;
               res_slot   = slot_in_ff;
            end else if (func_ff == FUNC_RELEASE) begin
               res_refs = cnt - REF_BITS'(1);
               wr_en    = 1'b1;
               wr_data  = res_refs;
               clr_use  = res_refs == '0;
            end else if (at_max) begin
               res_status = ST_OVF;
               res_refs   = cnt;
            end else begin
               res_refs = cnt + REF_BITS'(1);
               wr_en    = 1'b1;
               wr_data  = res_refs;
            end
         end
         default: begin
            res_slot = '0;
         end
      endcase
      if (!cmd.commit) begin
         wr_en     = 1'b0;
         set_use   = 1'b0;
         clr_use   = 1'b0;
         write_tag = 1'b0;
      end
   end

   assign refs_ext = {{REFSF_W{1'b0}}, res_refs};

   always_comb begin
      in_use_in = in_use_ff;
      if (set_use) begin
         in_use_in[tgt_ff] = 1'b1;
      end
      if (clr_use) begin
         in_use_in[tgt_ff] = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_use_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_use_ff    <= in_use_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         func_ff    <= req_func;
         dev_ff     <= req_dev_num;
         obj_ff     <= req_obj_num;
         slot_in_ff <= req_slot_in;
      end
      if (cmd.lookup) begin
         tgt_ff       <= look_tgt;
         hit_ff       <= hit_found;
         have_free_ff <= free_found;
         range_ok_ff  <= range_ok;
         tgt_used_ff  <= in_use_ff[look_tgt];
      end
      if (write_tag) begin
         tag_dev_ff[tgt_ff] <= dev_ff;
         tag_obj_ff[tgt_ff] <= obj_ff;
      end
      if (cmd.commit) begin
         rsp_slot_ff   <= res_slot;
         rsp_hit_ff    <= res_hit;
         rsp_status_ff <= res_status;
         rsp_refs_ff   <= refs_ext[REFSF_W-1:0];
      end
   end

   assign stat.out_busy = rsp_valid_ff && !rsp_ready;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_slot_out  = rsp_slot_ff;
   assign rsp_was_hit   = rsp_hit_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_refs_now  = rsp_refs_ff;

endmodule

/* src/refcounted_inode_slot_cache.sv */
`timescale 1ns / 1ps
// refcounted_inode_slot_cache: top level of the reference counted inode slot cache
// depends on irsc_pkg, irsc_if, irsc_ctrl, irsc_dp (and irsc_ram below it)

// Fully associative cache of SLOTS object slots, each keyed by (device, object)
// and carrying a REF_BITS-wide reference count; a slot with a zero count is
// free. Acquire finds the key among slots in use and bumps its count, or
// claims the lowest free slot with a count of one and reports was_hit low so
// that outside logic can load the metadata. Dup adds a reference to a slot,
// release drops one and frees the slot at zero. Full table, free or
// out-of-range slot and count overflow come back as error statuses with no
// change. Every request beat yields exactly one response beat. Each beat goes
// through capture, parallel tag compare with count ram read, then the count
// write-back into the result register, which waits while the previous
// response is still held; a new beat is taken the cycle after write-back and
// not before, so only one operation is in flight. The registered read of
// the count ram is why the write-back follows the tag compare as a step of
// its own. No clearing pass after reset: in-use flags in flops are cleared
// at once and the counts of unused slots are never trusted.

module refcounted_inode_slot_cache import irsc_pkg::*; #(
   parameter int SLOTS    = 64,
   parameter int REF_BITS = 16
) (
   input  logic       clock,
   input  logic       reset,
   irsc_req_if.sink   req_chan,
   irsc_rsp_if.source rsp_chan
);

   irsc_cmd_type  ctrl_cmd;
   irsc_stat_type dp_stat;

   // sequencer: capture, lookup, commit
   irsc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .stat      (dp_stat),
      .cmd       (ctrl_cmd)
   );

   // slot table, count ram and result register
   irsc_dp #(
      .SLOTS    (SLOTS),
      .REF_BITS (REF_BITS)
   ) u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (ctrl_cmd),
      .stat         (dp_stat),
      .req_func     (req_chan.func),
      .req_dev_num  (req_chan.dev_num),
      .req_obj_num  (req_chan.obj_num),
      .req_slot_in  (req_chan.slot_in),
      .rsp_ready    (rsp_chan.ready),
      .rsp_valid    (rsp_chan.valid),
      .rsp_slot_out (rsp_chan.slot_out),
      .rsp_was_hit  (rsp_chan.was_hit),
      .rsp_status   (rsp_chan.status),
      .rsp_refs_now (rsp_chan.refs_now)
   );

`ifndef SYNTH
   // one beat in flight: no accept straight after an accept
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_chan.valid && req_chan.ready |=> !req_chan.ready)
      else $error("request taken while another is in flight");

   // every write-back shows up as a response beat
   a_commit_visible: assert property (@(posedge clock) disable iff (reset)
      ctrl_cmd.commit |=> rsp_chan.valid)
      else $error("write-back without a response beat");

   // a full table reports no slot, no hit and no count
   a_full_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.status == ST_FULL
      |-> rsp_chan.slot_out == '0 && !rsp_chan.was_hit && rsp_chan.refs_now == '0)
      else $error("table full response carries data");

   // a free-slot error never claims a hit or a count
   a_free_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.status == ST_FREE
      |-> !rsp_chan.was_hit && rsp_chan.refs_now == '0)
      else $error("free slot response carries data");
`endif

endmodule
